// File: design/pde_pkg.sv
// Shared types, constants and helper functions for the polynomial derivative evaluator.
package pde_pkg;

    localparam int DATA_W         = 32;  // Q16.16 word
    localparam int DEG_W          = 3;   // degree and derivative order width
    localparam int CFG_IDX_W      = 4;   // config register index width
    localparam int FACT_W         = 10;  // largest falling factorial is 6! = 720
    localparam int MAX_DEGREE_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF0 = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;   // latch x and order, work out the top index
        logic setup;     // load acc with the top scaled coefficient
        logic mul;       // acc * x, scale the next coefficient
        logic acc;       // shift, add, clamp, step the index down
        logic load_out;  // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic done;       // no Horner steps left
        logic last_step;  // the step under way is the final one
        logic out_free;   // output register can take a result
    } t_status;

    // (j+k)!/j!, for j + k up to 6
    function automatic logic [FACT_W-1:0] fall_fact(input logic [DEG_W-1:0] j,
                                                    input logic [DEG_W-1:0] k);
        int f;
        int jj;
        int kk;
        f  = 1;
        jj = int'(j);
        kk = int'(k);
        for (int m = 1; m <= 6; m++) begin
            if (m > jj && m <= jj + kk) begin
                f = f * m;
            end
        end
        return FACT_W'(f);
    endfunction

endpackage

// File: design/pde_ctrl.sv
// Sequencer for the Horner evaluation: setup, multiply/accumulate loop, result hand-off.
module pde_ctrl
    import pde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = i_status.done ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = i_status.last_step ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a finished result waits while the output register is held
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_status.out_free) |=> (r_state == ST_DONE))
        else $error("result left DONE while output was blocked");

    // every accepted transaction goes through setup next
    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> (r_state == ST_SETUP))
        else $error("accepted transaction did not enter setup");

    // input side is open only while idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (r_state == ST_IDLE))
        else $error("ready outside idle");
`endif

endmodule

// File: design/pde_dp.sv
// Datapath: config registers, coefficient scaling, Horner multiply/accumulate, output register.
module pde_dp
    import pde_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic signed [DATA_W-1:0] i_point,
    input  logic [DEG_W-1:0]         i_order,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [DATA_W-1:0]        o_value,
    output logic                     o_sat
);

    localparam int NUM_COEFFS = MAX_DEGREE + 1;
    localparam int IDX_W      = $clog2(NUM_COEFFS);
    localparam int SC_W       = DATA_W + FACT_W + 1;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 1;

    localparam logic [DEG_W-1:0]       MAX_DEG_V = DEG_W'(MAX_DEGREE);
    localparam logic signed [SC_W-1:0] SC_MAX    = $signed(SC_W'(2**(DATA_W-1) - 1));
    localparam logic signed [SC_W-1:0] SC_MIN    = ~SC_MAX;
    localparam logic signed [SUM_W-1:0] SUM_MAX  = $signed(SUM_W'(2**(DATA_W-1) - 1));
    localparam logic signed [SUM_W-1:0] SUM_MIN  = ~SUM_MAX;

    // config state
    logic [DEG_W-1:0]         r_degree;
    logic signed [DATA_W-1:0] r_coeff [NUM_COEFFS];

    // working registers
    logic signed [DATA_W-1:0] r_x;
    logic [DEG_W-1:0]         r_k;
    logic [DEG_W-1:0]         r_j;
    logic                     r_zero;
    logic signed [DATA_W-1:0] r_acc;
    logic                     r_sat;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_d;
    logic                     r_dsat;

    // output register
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_value;
    logic                     r_out_sat;

    logic [DEG_W-1:0]         eff_deg;
    logic [DEG_W-1:0]         sel_j;
    logic [DEG_W-1:0]         coef_idx;
    logic signed [DATA_W-1:0] coef;
    logic [FACT_W-1:0]        fact;
    logic signed [SC_W-1:0]   sc_prod;
    logic signed [DATA_W-1:0] sc_val;
    logic                     sc_sat;
    logic signed [PROD_W-1:0] shifted;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DATA_W-1:0] sum_val;
    logic                     sum_sat;

    assign eff_deg = (r_degree > MAX_DEG_V) ? MAX_DEG_V : r_degree;

    // coefficient for d[sel_j] of the k-th derivative
    assign sel_j    = i_cmd.mul ? (r_j - DEG_W'(1)) : r_j;
    assign coef_idx = sel_j + r_k;
    assign coef     = r_coeff[coef_idx[IDX_W-1:0]];
    assign fact     = fall_fact(sel_j, r_k);
    assign sc_prod  = coef * $signed({1'b0, fact});
    assign sc_sat   = (sc_prod > SC_MAX) || (sc_prod < SC_MIN);
    assign sc_val   = (sc_prod > SC_MAX) ? SC_MAX[DATA_W-1:0] :
                      (sc_prod < SC_MIN) ? SC_MIN[DATA_W-1:0] : sc_prod[DATA_W-1:0];

    // Horner step: floor shift of acc*x, add next coefficient, clamp
    assign shifted = r_prod >>> FRAC_BITS;
    assign sum     = shifted + r_d;
    assign sum_sat = (sum > SUM_MAX) || (sum < SUM_MIN);
    assign sum_val = (sum > SUM_MAX) ? SUM_MAX[DATA_W-1:0] :
                     (sum < SUM_MIN) ? SUM_MIN[DATA_W-1:0] : sum[DATA_W-1:0];

    assign o_status.done      = r_zero || (r_j == '0);
    assign o_status.last_step = (r_j == DEG_W'(1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree    <= '0;
            r_coeff     <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_DEGREE) begin
                    r_degree <= i_cfg_data[DEG_W-1:0];
                end
                for (int i = 0; i < NUM_COEFFS; i++) begin
                    if (i_cfg_index == CFG_COEFF0 + CFG_IDX_W'(i)) begin
                        r_coeff[i] <= i_cfg_data;
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x    <= i_point;
            r_k    <= i_order;
            r_zero <= i_order > eff_deg;
            r_j    <= eff_deg - i_order;
        end
        if (i_cmd.setup) begin
            r_acc <= r_zero ? '0 : sc_val;
            r_sat <= r_zero ? 1'b0 : sc_sat;
        end
        if (i_cmd.mul) begin
            r_prod <= r_acc * r_x;
            r_d    <= sc_val;
            r_dsat <= sc_sat;
        end
        if (i_cmd.acc) begin
            r_acc <= sum_val;
            r_sat <= r_sat | r_dsat | sum_sat;
            r_j   <= r_j - DEG_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out_value <= r_acc;
            r_out_sat   <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_sat       = r_out_sat;

`ifndef NO_ASSERTIONS
    // no Horner step runs past the constant term
    a_acc_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |-> (r_j != '0))
        else $error("Horner step with index already at zero");

    // order above degree gives a clean zero
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_zero) |=> (o_value == '0 && !o_sat))
        else $error("out-of-range order did not give zero");

    // a result never overwrites one that is still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while stalled");
`endif

endmodule

// File: design/polynomial_derivative_evaluator.sv
// Top level of the polynomial derivative evaluator: controller plus datapath.
// Usage:
//   Slave channel: s_axis_tdata carries the point x (signed Q16.16), s_axis_tuser
//   the derivative order k. One transaction in gives one transaction out on the
//   master channel: m_axis_tdata is the k-th derivative at x (signed Q16.16,
//   clamped), m_axis_tuser is set if any scaling or Horner step clamped.
//   Config port: write i_cfg_data to register i_cfg_index while i_cfg_wr_en is
//   high. Index 0 is the degree, 1..7 the coefficients c0..c6. Other indexes are
//   dropped. Write only while no transaction is in flight.
// Sequencing:
//   One item at a time. With t = min(degree, MAX_DEGREE) - k Horner steps
//   (t = 0 when k exceeds the degree), an accepted item passes through setup,
//   t Horner steps and done, where the result moves into the output register;
//   the next item is taken only after that, back in idle. Each Horner step is
//   a multiply state (acc*x, next coefficient scaled in parallel) and an
//   accumulate state (shift, add, clamp).
//   s_axis_tready is high in idle, so a new item is taken while the previous
//   result still sits in the output register.
// Reset: synchronous, active low; clears degree and coefficients to zero and
//   empties the output register. A stalled m_axis_tready holds the result and
//   holds the next item in its final state until the register frees.
module polynomial_derivative_evaluator
    import pde_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // slave channel
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] point
    input  logic [DEG_W-1:0]     s_axis_tuser,   // [2:0] deriv_order
    // master channel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] value
    output logic                 m_axis_tuser    // [0] saturated
);

    t_cmd    cmd;
    t_status status;

    pde_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pde_dp #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_point     ($signed(s_axis_tdata)),
        .i_order     (s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_value     (m_axis_tdata),
        .o_sat       (m_axis_tuser)
    );

endmodule
